[sv/cqr_pkg.sv]
package cqr_pkg;

	localparam int unsigned DEPTH_DEF = 8;
	localparam int unsigned DATA_W    = 32;

	// operation codes of an input word
	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_DISP = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	// controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_DISP = 1'b1
	} state_t;

	// result request handed from the controller to the output stage
	typedef struct packed {
		logic    valid;
		logic    use_mem;
		status_t status;
		logic    last;
	} issue_t;

endpackage

[sv/cqr_mem.sv]
module cqr_mem #(
	parameter int unsigned DEPTH = cqr_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [$clog2(DEPTH)-1:0]           wr_addr,
	input  logic signed [cqr_pkg::DATA_W-1:0]  wr_data,
	input  logic                               rd_en,
	input  logic [$clog2(DEPTH)-1:0]           rd_addr,
	output logic signed [cqr_pkg::DATA_W-1:0]  rd_data
);

	logic signed [cqr_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic signed [cqr_pkg::DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/cqr_ctrl.sv]
module cqr_ctrl #(
	parameter int unsigned DEPTH = cqr_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         operation,
	input  logic signed [cqr_pkg::DATA_W-1:0]  push_value,
	input  logic                               advance,
	output cqr_pkg::issue_t                    issue,
	output logic                               rd_en,
	output logic [$clog2(DEPTH)-1:0]           rd_addr,
	output logic                               wr_en,
	output logic [$clog2(DEPTH)-1:0]           wr_addr,
	output logic signed [cqr_pkg::DATA_W-1:0]  wr_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cqr_pkg::state_t state_q, state_nxt;
	logic [AW-1:0]   head_q, tail_q, ptr_q;
	logic [CW-1:0]   occ_q, remain_q;
	logic            accept, full, empty, disp_last;
	cqr_pkg::op_t    op;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
		next_slot = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
	endfunction

	assign op        = cqr_pkg::op_t'(operation);
	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign accept    = in_valid && in_ready;
	assign disp_last = (remain_q == CW'(1));
	assign wr_data   = push_value;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			cqr_pkg::S_IDLE: begin
				if (accept && op == cqr_pkg::OP_DISP && !empty) begin
					state_nxt = cqr_pkg::S_DISP;
				end
			end
			cqr_pkg::S_DISP: begin
				if (advance && disp_last) begin
					state_nxt = cqr_pkg::S_IDLE;
				end
			end
			default: state_nxt = cqr_pkg::S_IDLE;
		endcase
	end

	// outputs: handshake, memory access and result request
	always_comb begin
		in_ready       = 1'b0;
		issue.valid    = 1'b0;
		issue.use_mem  = 1'b0;
		issue.status   = cqr_pkg::ST_OK;
		issue.last     = 1'b1;
		rd_en          = 1'b0;
		rd_addr        = head_q;
		wr_en          = 1'b0;
		wr_addr        = tail_q;
		unique case (state_q)
			cqr_pkg::S_IDLE: begin
				in_ready = advance;
				if (in_valid && advance) begin
					unique case (op)
						cqr_pkg::OP_ENQ: begin
							issue.valid  = 1'b1;
							issue.status = full ? cqr_pkg::ST_OVERFLOW : cqr_pkg::ST_OK;
							wr_en        = !full;
						end
						cqr_pkg::OP_DEQ: begin
							issue.valid   = 1'b1;
							issue.status  = empty ? cqr_pkg::ST_EMPTY : cqr_pkg::ST_OK;
							issue.use_mem = !empty;
							rd_en         = !empty;
						end
						cqr_pkg::OP_DISP: begin
							// non-empty display is walked in S_DISP
							if (empty) begin
								issue.valid  = 1'b1;
								issue.status = cqr_pkg::ST_EMPTY;
							end
						end
						cqr_pkg::OP_NONE: begin
							// no result
						end
						default: ;
					endcase
				end
			end
			cqr_pkg::S_DISP: begin
				if (advance) begin
					issue.valid   = 1'b1;
					issue.use_mem = 1'b1;
					issue.last    = disp_last;
					rd_en         = 1'b1;
					rd_addr       = ptr_q;
				end
			end
			default: ;
		endcase
	end

	// queue pointers, occupancy and display walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cqr_pkg::S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			occ_q    <= '0;
			ptr_q    <= '0;
			remain_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				tail_q <= next_slot(tail_q);
				occ_q  <= occ_q + CW'(1);
			end
			if (rd_en && state_q == cqr_pkg::S_IDLE) begin
				head_q <= next_slot(head_q);
				occ_q  <= occ_q - CW'(1);
			end
			if (accept && op == cqr_pkg::OP_DISP) begin
				ptr_q    <= head_q;
				remain_q <= occ_q;
			end else if (state_q == cqr_pkg::S_DISP && advance) begin
				ptr_q    <= next_slot(ptr_q);
				remain_q <= remain_q - CW'(1);
			end
		end
	end

endmodule

[sv/cqr_out.sv]
module cqr_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cqr_pkg::issue_t                    issue,
	input  logic signed [cqr_pkg::DATA_W-1:0]  rd_data,
	output logic                               advance,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic signed [cqr_pkg::DATA_W-1:0]  data_value,
	output logic                               last
);

	logic              valid_s1, use_mem_s1, last_s1;
	cqr_pkg::status_t  status_s1, status_q;
	logic              out_valid_q, last_q;
	logic signed [cqr_pkg::DATA_W-1:0] data_q;
	logic              move_s1;

	// s1 waits on the memory read; it moves when the output word is free
	assign move_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign advance = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= issue.valid;
			end
			if (move_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (advance) begin
			use_mem_s1 <= issue.use_mem;
			status_s1  <= issue.status;
			last_s1    <= issue.last;
		end
		if (move_s1) begin
			status_q <= status_s1;
			last_q   <= last_s1;
			data_q   <= use_mem_s1 ? rd_data : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign data_value = data_q;
	assign last       = last_q;

endmodule

[sv/circular_queue_with_readout.sv]
// A result word passes the memory read and stage s1, then the output register;
// a display's first word also waits for the controller to enter S_DISP.
// Throughput: enqueue and dequeue take one word per cycle while the output side
// does not stall; a display holds off the input until its last entry is issued
// and emits one word per cycle while not stalled. Reset clears head, tail,
// occupancy and the pipeline valids; entry storage is not cleared.
module circular_queue_with_readout #(
	parameter int unsigned DEPTH = cqr_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         operation,
	input  logic signed [cqr_pkg::DATA_W-1:0]  push_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic signed [cqr_pkg::DATA_W-1:0]  data_value,
	output logic                               last
);

	localparam int unsigned AW = $clog2(DEPTH);

	cqr_pkg::issue_t                   issue;
	logic                              advance, rd_en, wr_en;
	logic [AW-1:0]                     rd_addr, wr_addr;
	logic signed [cqr_pkg::DATA_W-1:0] wr_data, rd_data;

	// pointers, occupancy and display sequencing
	cqr_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.push_value (push_value),
		.advance    (advance),
		.issue      (issue),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// entry storage; one op per cycle so a read never meets a same-cycle write
	cqr_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// read stage and output register
	cqr_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.rd_data    (rd_data),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.data_value (data_value),
		.last       (last)
	);

endmodule

[verif/circular_queue_with_readout_tb.sv]
`timescale 1ns / 1ps

module circular_queue_with_readout_tb;

	localparam int unsigned QDEPTH = cqr_pkg::DEPTH_DEF;
	localparam int N_DIR = 21;
	localparam int N_RAND = 160;
	localparam int HOLD_CYCLES = 80;

	// one result word as seen on the output side
	typedef struct {
		cqr_pkg::status_t    st;
		logic signed [31:0]  data;
		logic                last;
	} res_word_t;

	// one row of the directed table; typed rows carry their single result
	typedef struct {
		cqr_pkg::op_t        op;
		logic signed [31:0]  val;
		bit                  typed;
		cqr_pkg::status_t    st;
		logic signed [31:0]  data;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         operation = cqr_pkg::OP_NONE;
	logic signed [31:0] push_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] data_value;
	logic               last;

	// shadow copy of the queue
	logic signed [31:0] shadow_slots [QDEPTH];
	int unsigned        shadow_head = 0;
	int unsigned        shadow_tail = 0;
	int unsigned        shadow_count = 0;

	res_word_t          pending_words [$];
	int                 err_cnt = 0;

	// traffic shaping; no_idle is shared by sender and receiver, the hold-off is the receiver's
	bit                 no_idle = 1'b0;
	bit                 hold_go = 1'b0;
	bit                 hold_done = 1'b0;
	int                 hold_cnt = 0;

	dir_row_t dir_rows [N_DIR] = '{
		'{cqr_pkg::OP_DEQ,  32'h0000_0000, 1'b1, cqr_pkg::ST_EMPTY,    32'h0000_0000},
		'{cqr_pkg::OP_DISP, 32'h0000_0000, 1'b1, cqr_pkg::ST_EMPTY,    32'h0000_0000},
		'{cqr_pkg::OP_NONE, 32'h1234_5678, 1'b0, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_ENQ,  32'h7FFF_FFFF, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_DEQ,  32'h0000_0000, 1'b1, cqr_pkg::ST_OK,       32'h7FFF_FFFF},
		'{cqr_pkg::OP_ENQ,  32'h8000_0000, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_ENQ,  32'hFFFF_FFFF, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_ENQ,  32'h0000_0000, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_ENQ,  32'h5555_5555, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_ENQ,  32'hAAAA_AAAA, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_ENQ,  32'h0000_0001, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_ENQ,  32'h1234_5678, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_ENQ,  32'hDEAD_BEEF, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_ENQ,  32'h0F0F_0F0F, 1'b1, cqr_pkg::ST_OVERFLOW, 32'h0000_0000},
		'{cqr_pkg::OP_DISP, 32'h0000_0000, 1'b0, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_DEQ,  32'h0000_0000, 1'b1, cqr_pkg::ST_OK,       32'h8000_0000},
		'{cqr_pkg::OP_ENQ,  32'h7FFF_FFFF, 1'b1, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_DISP, 32'h0000_0000, 1'b0, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_NONE, 32'hFFFF_FFFF, 1'b0, cqr_pkg::ST_OK,       32'h0000_0000},
		'{cqr_pkg::OP_DEQ,  32'h0000_0000, 1'b1, cqr_pkg::ST_OK,       32'hFFFF_FFFF},
		'{cqr_pkg::OP_DISP, 32'h0000_0000, 1'b0, cqr_pkg::ST_OK,       32'h0000_0000}
	};

	circular_queue_with_readout #(
		.DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.data_value(data_value),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned slot_after(input int unsigned idx);
		return (idx + 1 >= QDEPTH) ? 0 : idx + 1;
	endfunction

	// advance the shadow queue by one word and collect the words it answers with
	function automatic void queue_step(input cqr_pkg::op_t op,
			input logic signed [31:0] val, ref res_word_t words [$]);
		int unsigned idx;
		words = {};
		case (op)
			cqr_pkg::OP_ENQ: begin
				if (shadow_count >= QDEPTH) begin
					words.push_back('{cqr_pkg::ST_OVERFLOW, '0, 1'b1});
				end else begin
					shadow_slots[shadow_tail] = val;
					shadow_tail = slot_after(shadow_tail);
					shadow_count++;
					words.push_back('{cqr_pkg::ST_OK, '0, 1'b1});
				end
			end
			cqr_pkg::OP_DEQ: begin
				if (shadow_count == 0) begin
					words.push_back('{cqr_pkg::ST_EMPTY, '0, 1'b1});
				end else begin
					words.push_back('{cqr_pkg::ST_OK, shadow_slots[shadow_head], 1'b1});
					shadow_head = slot_after(shadow_head);
					shadow_count--;
				end
			end
			cqr_pkg::OP_DISP: begin
				if (shadow_count == 0) begin
					words.push_back('{cqr_pkg::ST_EMPTY, '0, 1'b1});
				end else begin
					idx = shadow_head;
					for (int k = 0; k < shadow_count; k++) begin
						words.push_back('{cqr_pkg::ST_OK, shadow_slots[idx],
							k == shadow_count - 1});
						idx = slot_after(idx);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// offer one word, wait for the handshake, then book its expected results
	task automatic send_word(input cqr_pkg::op_t op, input logic signed [31:0] val,
			input bit typed, input res_word_t typed_res);
		res_word_t words [$];
		while (!no_idle && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		push_value <= val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		queue_step(op, val, words);
		if (typed)
			pending_words.push_back(typed_res);
		else
			foreach (words[i]) pending_words.push_back(words[i]);
	endtask

	task automatic drain_all();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, one long hold-off, and a stretch with none
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (no_idle) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 36);
		end
	end

	// compare every accepted result word with the oldest expectation
	always @(posedge clk) begin
		res_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word status=%0d data=%h last=%0d",
					$realtime, status, data_value, last);
				err_cnt++;
			end else begin
				exp_w = pending_words.pop_front();
				if (status !== exp_w.st) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, exp_w.st, status);
					err_cnt++;
				end
				if (data_value !== exp_w.data) begin
					$display("%0t: data_value expected %h actual %h",
						$realtime, exp_w.data, data_value);
					err_cnt++;
				end
				if (last !== exp_w.last) begin
					$display("%0t: last expected %0d actual %0d",
						$realtime, exp_w.last, last);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		cqr_pkg::op_t       op;
		logic signed [31:0] val;
		int                 enq_w;
		int                 deq_w;
		int                 pick;
		res_word_t          typed_res;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIR; i++) begin
			typed_res = '{dir_rows[i].st, dir_rows[i].data, 1'b1};
			send_word(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed, typed_res);
		end
		drain_all();

		// random traffic, alternating fill-heavy and drain-heavy phases
		for (int i = 0; i < N_RAND; i++) begin
			if (i == 40)
				hold_go = 1'b1;
			if (i == 90)
				drain_all();
			no_idle = (i >= 100 && i < 150);
			if (i >= 40 && i < 70) begin
				enq_w = 80;
				deq_w = 5;
			end else if ((i / 30) % 2 == 0) begin
				enq_w = 55;
				deq_w = 20;
			end else begin
				enq_w = 20;
				deq_w = 55;
			end
			pick = $urandom_range(99);
			if (pick < enq_w)
				op = cqr_pkg::OP_ENQ;
			else if (pick < enq_w + deq_w)
				op = cqr_pkg::OP_DEQ;
			else if (pick < 95)
				op = cqr_pkg::OP_DISP;
			else
				op = cqr_pkg::OP_NONE;
			case ($urandom_range(9))
				0: val = 32'h7FFF_FFFF;
				1: val = 32'h8000_0000;
				2: val = 32'h0000_0000;
				3: val = 32'hFFFF_FFFF;
				default: val = $urandom;
			endcase
			send_word(op, val, 1'b0, typed_res);
		end
		no_idle = 1'b0;
		drain_all();
		repeat (20) @(posedge clk);

		if (err_cnt == 0) begin
			$display("circular_queue_with_readout test passed");
		end else begin
			$display("circular_queue_with_readout test failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1000000;
		$display("circular_queue_with_readout test failed");
		$finish;
	end

endmodule

[files.f]
sv/cqr_pkg.sv
sv/cqr_mem.sv
sv/cqr_ctrl.sv
sv/cqr_out.sv
sv/circular_queue_with_readout.sv
verif/circular_queue_with_readout_tb.sv
